### hdl/hsr_pkg.sv
// Shared types, widths and the gamma lookup table for the haze scene radiance recovery block.
// Used by hsr_front, hsr_div_step and haze_scene_radiance_recover_top; depends on nothing else.
package hsr_pkg;

  // Field widths.
  localparam int PIX_W           = 8;
  localparam int LIGHT_W         = 16;
  localparam int TRANS_FRAC_BITS = 12;
  localparam int TRANS_W         = TRANS_FRAC_BITS + 1;
  localparam int CFG_IDX_W       = 2;

  // Radiance arithmetic: N = d * 2^(F+1) + t * (2A + 256), D = 512 * t.
  localparam int D_W       = LIGHT_W + 2;          // signed 256*I - A
  localparam int M_W       = LIGHT_W + 2;          // 2A + 256
  localparam int P_W       = TRANS_W + M_W;        // t * (2A + 256)
  localparam int N_W       = P_W + 1;              // signed numerator
  localparam int QUO_W     = PIX_W;                // quotient bits kept
  localparam int DEN_SH    = PIX_W + 1;            // D = t << DEN_SH
  localparam int SAT_SH    = DEN_SH + QUO_W;       // 256 * D = t << SAT_SH
  localparam int REM_W     = TRANS_W + SAT_SH;     // remainder below 256 * D
  localparam int QB_W      = $clog2(QUO_W);
  localparam int NUM_STEPS = QUO_W / 2;            // two quotient bits per stage

  localparam logic [LIGHT_W-1:0] LIGHT_RESET = 16'hFF00;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_CH0 = 2'd0,
    REG_LIGHT_CH1 = 2'd1,
    REG_LIGHT_CH2 = 2'd2
  } cfg_reg_t;

  // State of one channel as it moves through the divider.
  typedef struct packed {
    logic               neg;
    logic               sat;
    logic [TRANS_W-1:0] te;
    logic [REM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
  } hsr_div_t;

  typedef logic [255:0][PIX_W-1:0] gamma_lut_t;

  // Builds G(i) = round(255 * (i/255)^0.7) by exact integer comparison of
  // (2y+1)^10 against 1024 * 255^3 * i^7, searching y by bisection.
  function automatic gamma_lut_t gamma_build();
    gamma_lut_t  lut;
    logic [95:0] rhs;
    logic [95:0] lhs;
    int          i;
    int          k;
    int          lo;
    int          hi;
    int          mid;
    lut = '0;
    for (i = 0; i < 256; i++) begin
      rhs = 96'd16979328000;
      for (k = 0; k < 7; k++) begin
        rhs = rhs * 96'(i);
      end
      lo = 0;
      hi = 255;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        lhs = 96'd1;
        for (k = 0; k < 10; k++) begin
          lhs = lhs * 96'(2 * mid + 1);
        end
        if (lhs > rhs) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      lut[i] = lo[PIX_W-1:0];
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = gamma_build();

endpackage

### hdl/hsr_front.sv
// Front end of one color channel: multiply stage and numerator/saturation stage.
// Depends on hsr_pkg for widths and the divider state type.
module hsr_front (
  input  logic                           clk,
  input  logic [hsr_pkg::PIX_W-1:0]      pix,
  input  logic [hsr_pkg::LIGHT_W-1:0]    light,
  input  logic [hsr_pkg::TRANS_W-1:0]    trans,
  output hsr_pkg::hsr_div_t              div_out
);

  logic [hsr_pkg::TRANS_W-1:0]  te_c;
  logic signed [hsr_pkg::D_W-1:0] d_c;
  logic [hsr_pkg::M_W-1:0]      m_c;
  logic [hsr_pkg::P_W-1:0]      p_c;

  logic signed [hsr_pkg::D_W-1:0] d_q;
  logic [hsr_pkg::P_W-1:0]      p_q;
  logic [hsr_pkg::TRANS_W-1:0]  te_q;

  logic signed [hsr_pkg::N_W-1:0] n_c;
  logic [hsr_pkg::N_W-1:0]      thr_c;
  hsr_pkg::hsr_div_t            div_c;

  // Stage one: zero transmission is raised to one LSB, then the offset
  // 256*I - A and the product t * (2A + 256) are formed.
  always_comb begin
    te_c = (trans == '0) ? hsr_pkg::TRANS_W'(1) : trans;
    d_c  = $signed({2'b00, pix, 8'h00}) - $signed({2'b00, light});
    m_c  = {1'b0, light, 1'b0} + hsr_pkg::M_W'(256);
    p_c  = {{hsr_pkg::M_W{1'b0}}, te_c} * {{hsr_pkg::TRANS_W{1'b0}}, m_c};
  end

  always_ff @(posedge clk) begin
    d_q  <= d_c;
    p_q  <= p_c;
    te_q <= te_c;
  end

  // Stage two: full numerator, sign check and saturation check against 256 * D.
  always_comb begin
    n_c = ($signed({{(hsr_pkg::N_W - hsr_pkg::D_W){d_q[hsr_pkg::D_W-1]}}, d_q})
           <<< (hsr_pkg::TRANS_FRAC_BITS + 1)) + $signed({1'b0, p_q});
    thr_c = {{(hsr_pkg::N_W - hsr_pkg::TRANS_W){1'b0}}, te_q} << hsr_pkg::SAT_SH;
    div_c.neg = n_c[hsr_pkg::N_W-1];
    div_c.sat = !n_c[hsr_pkg::N_W-1] && ($unsigned(n_c) >= thr_c);
    div_c.te  = te_q;
    div_c.rem = n_c[hsr_pkg::REM_W-1:0];
    div_c.quo = '0;
  end

  always_ff @(posedge clk) begin
    div_out <= div_c;
  end

endmodule

### hdl/hsr_div_step.sv
// One divider stage: two restoring compare-subtract steps on one channel.
// Depends on hsr_pkg for the divider state type and widths.
module hsr_div_step (
  input  logic                       clk,
  input  logic [hsr_pkg::QB_W-1:0]   bit_hi,
  input  hsr_pkg::hsr_div_t          div_in,
  output hsr_pkg::hsr_div_t          div_out
);

  logic [hsr_pkg::QB_W-1:0]  bit_lo;
  logic [hsr_pkg::REM_W-1:0] den_hi;
  logic [hsr_pkg::REM_W-1:0] den_lo;
  logic [hsr_pkg::REM_W-1:0] rem_mid;
  logic                      q_hi;
  logic                      q_lo;
  hsr_pkg::hsr_div_t         div_c;

  // Quotient bits bit_hi and bit_hi - 1, each against D shifted into place.
  always_comb begin
    bit_lo  = bit_hi - hsr_pkg::QB_W'(1);
    den_hi  = hsr_pkg::REM_W'(div_in.te) << (hsr_pkg::DEN_SH + int'(bit_hi));
    den_lo  = hsr_pkg::REM_W'(div_in.te) << (hsr_pkg::DEN_SH + int'(bit_lo));
    q_hi    = (div_in.rem >= den_hi);
    rem_mid = q_hi ? (div_in.rem - den_hi) : div_in.rem;
    q_lo    = (rem_mid >= den_lo);
    div_c     = div_in;
    div_c.rem = q_lo ? (rem_mid - den_lo) : rem_mid;
    div_c.quo = div_in.quo
              | (hsr_pkg::QUO_W'(q_hi) << bit_hi)
              | (hsr_pkg::QUO_W'(q_lo) << bit_lo);
  end

  always_ff @(posedge clk) begin
    div_out <= div_c;
  end

endmodule

### hdl/haze_scene_radiance_recover_top.sv
// out_valid comes from a valid chain that runs in step with the result registers.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls.
// Depth is set by the two front stages, four two-bit divider stages and the gamma ROM stage.
// Reset (synchronous rst) clears the valid chain and sets every light register to 255.0.
// Top level of the haze scene radiance recovery block; uses hsr_pkg, hsr_front and hsr_div_step.
module haze_scene_radiance_recover_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [hsr_pkg::PIX_W-1:0]         pix_ch0,
  input  logic [hsr_pkg::PIX_W-1:0]         pix_ch1,
  input  logic [hsr_pkg::PIX_W-1:0]         pix_ch2,
  input  logic [hsr_pkg::TRANS_W-1:0]       trans,
  output logic                              out_valid,
  output logic [hsr_pkg::PIX_W-1:0]         out_ch0,
  output logic [hsr_pkg::PIX_W-1:0]         out_ch1,
  output logic [hsr_pkg::PIX_W-1:0]         out_ch2,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsr_pkg::LIGHT_W-1:0]       cfg_data
);

  localparam int VLD_N = hsr_pkg::NUM_STEPS + 3;

  logic [hsr_pkg::LIGHT_W-1:0] light [3];
  logic [hsr_pkg::PIX_W-1:0]   pix   [3];
  logic [hsr_pkg::PIX_W-1:0]   out_q [3];
  hsr_pkg::hsr_div_t           div_s [3][hsr_pkg::NUM_STEPS+1];
  logic [VLD_N-1:0]            vld;

  // The pipeline takes a pixel and a register write in every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign pix[0] = pix_ch0;
  assign pix[1] = pix_ch1;
  assign pix[2] = pix_ch2;

  // Atmospheric light registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      light[0] <= hsr_pkg::LIGHT_RESET;
      light[1] <= hsr_pkg::LIGHT_RESET;
      light[2] <= hsr_pkg::LIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hsr_pkg::cfg_reg_t'(cfg_index))
        hsr_pkg::REG_LIGHT_CH0: light[0] <= cfg_data;
        hsr_pkg::REG_LIGHT_CH1: light[1] <= cfg_data;
        hsr_pkg::REG_LIGHT_CH2: light[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the channel data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[VLD_N-2:0], start && !busy};
    end
  end

  assign out_valid = vld[VLD_N-1];

  // Per channel: front end, divider stages, then saturation and gamma lookup.
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    hsr_front u_front (
      .clk     (clk),
      .pix     (pix[ch]),
      .light   (light[ch]),
      .trans   (trans),
      .div_out (div_s[ch][0])
    );

    for (genvar s = 0; s < hsr_pkg::NUM_STEPS; s++) begin : g_step
      hsr_div_step u_step (
        .clk     (clk),
        .bit_hi  (hsr_pkg::QB_W'(hsr_pkg::QUO_W - 1 - 2 * s)),
        .div_in  (div_s[ch][s]),
        .div_out (div_s[ch][s+1])
      );
    end

    logic [hsr_pkg::PIX_W-1:0] j_c;

    always_comb begin
      priority if (div_s[ch][hsr_pkg::NUM_STEPS].neg) begin
        j_c = '0;
      end else if (div_s[ch][hsr_pkg::NUM_STEPS].sat) begin
        j_c = '1;
      end else begin
        j_c = div_s[ch][hsr_pkg::NUM_STEPS].quo;
      end
    end

    always_ff @(posedge clk) begin
      out_q[ch] <= hsr_pkg::GAMMA_LUT[j_c];
    end
  end

  assign out_ch0 = out_q[0];
  assign out_ch1 = out_q[1];
  assign out_ch2 = out_q[2];

endmodule

### dv/tb.sv
// Self-checking testbench for haze_scene_radiance_recover_top.
// Depends on hsr_pkg and the top level under hdl; predicts each pixel with its own
// radiance arithmetic and gamma table, and checks results in order through a scoreboard class.
`timescale 1ns / 100ps

module tb;

  localparam int PIPE_LATENCY = 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 6;

  // Index past the last light register; writes to it must be ignored.
  localparam logic [hsr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [hsr_pkg::PIX_W-1:0] ch0;
    logic [hsr_pkg::PIX_W-1:0] ch1;
    logic [hsr_pkg::PIX_W-1:0] ch2;
  } rgb_t;

  // Predicts recovered pixels and checks them in arrival order.
  class radiance_scoreboard;
    logic [hsr_pkg::PIX_W-1:0]   gamma_rom [256];
    logic [hsr_pkg::LIGHT_W-1:0] light [3];
    rgb_t                        expected_pixels [$];
    int                          mismatches;

    // The gamma entry for i is the smallest y with (2y+1)^10 above 1024 * 255^3 * i^7,
    // or 255 when there is none. The entries never decrease, so the search resumes.
    function new();
      logic [127:0] rhs;
      logic [127:0] odd_pow;
      int           y;
      int           i;
      int           k;
      bit           found;
      y = 0;
      for (i = 0; i < 256; i++) begin
        rhs = 128'd1024;
        for (k = 0; k < 3; k++) rhs = rhs * 128'd255;
        for (k = 0; k < 7; k++) rhs = rhs * 128'(i);
        found = 1'b0;
        while (!found) begin
          if (y == 255) begin
            found = 1'b1;
          end else begin
            odd_pow = 128'd1;
            for (k = 0; k < 10; k++) odd_pow = odd_pow * 128'(2 * y + 1);
            if (odd_pow > rhs) begin
              found = 1'b1;
            end else begin
              y++;
            end
          end
        end
        gamma_rom[i] = y[hsr_pkg::PIX_W-1:0];
      end
      for (i = 0; i < 3; i++) light[i] = hsr_pkg::LIGHT_RESET;
      mismatches = 0;
    endfunction

    function void write_light(logic [hsr_pkg::CFG_IDX_W-1:0] idx,
                              logic [hsr_pkg::LIGHT_W-1:0] val);
      case (idx)
        hsr_pkg::REG_LIGHT_CH0: light[0] = val;
        hsr_pkg::REG_LIGHT_CH1: light[1] = val;
        hsr_pkg::REG_LIGHT_CH2: light[2] = val;
        default: ;
      endcase
    endfunction

    // J = (I - A) / t + A, rounded half up, clamped to 0..255, then gamma mapped.
    function logic [hsr_pkg::PIX_W-1:0] radiance(logic [hsr_pkg::PIX_W-1:0] pix,
                                                 logic [hsr_pkg::LIGHT_W-1:0] a,
                                                 logic [hsr_pkg::TRANS_W-1:0] t);
      longint te;
      longint diff;
      longint num;
      longint den;
      longint twice;
      longint q;
      te    = (t == '0) ? 64'sd1 : longint'(t);
      diff  = longint'(pix) * 256 - longint'(a);
      num   = diff * (64'sd1 <<< hsr_pkg::TRANS_FRAC_BITS) + longint'(a) * te;
      den   = te * 256;
      twice = 2 * num + den;
      if (twice < 0) begin
        q = 0;
      end else begin
        q = twice / (2 * den);
        if (q > 255) q = 255;
      end
      return gamma_rom[q];
    endfunction

    function void note_pixel(logic [hsr_pkg::PIX_W-1:0] p0, logic [hsr_pkg::PIX_W-1:0] p1,
                             logic [hsr_pkg::PIX_W-1:0] p2, logic [hsr_pkg::TRANS_W-1:0] t);
      rgb_t e;
      e.ch0 = radiance(p0, light[0], t);
      e.ch1 = radiance(p1, light[1], t);
      e.ch2 = radiance(p2, light[2], t);
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel(logic [hsr_pkg::PIX_W-1:0] o0, logic [hsr_pkg::PIX_W-1:0] o1,
                              logic [hsr_pkg::PIX_W-1:0] o2);
      rgb_t e;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result ch0=%0d ch1=%0d ch2=%0d", $realtime, o0, o1, o2);
      end else begin
        e = expected_pixels.pop_front();
        if (o0 !== e.ch0 || o1 !== e.ch1 || o2 !== e.ch2) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch expected ch0=%0d ch1=%0d ch2=%0d got ch0=%0d ch1=%0d ch2=%0d",
                     $realtime, e.ch0, e.ch1, e.ch2, o0, o1, o2);
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [hsr_pkg::PIX_W-1:0]     pix_ch0;
  logic [hsr_pkg::PIX_W-1:0]     pix_ch1;
  logic [hsr_pkg::PIX_W-1:0]     pix_ch2;
  logic [hsr_pkg::TRANS_W-1:0]   trans;
  logic                          out_valid;
  logic [hsr_pkg::PIX_W-1:0]     out_ch0;
  logic [hsr_pkg::PIX_W-1:0]     out_ch1;
  logic [hsr_pkg::PIX_W-1:0]     out_ch2;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hsr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hsr_pkg::LIGHT_W-1:0]   cfg_data;

  radiance_scoreboard sb;
  int                 burst_left;
  int                 cycle_count;

  haze_scene_radiance_recover_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pix_ch0   (pix_ch0),
    .pix_ch1   (pix_ch1),
    .pix_ch2   (pix_ch2),
    .trans     (trans),
    .out_valid (out_valid),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1) sb.check_pixel(out_ch0, out_ch1, out_ch2);
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** haze_scene_radiance_recover_top: FAILED **");
    $finish;
  end

  // Presents one pixel and holds it until the start transfer; start stays high.
  task automatic send_pixel(input logic [hsr_pkg::PIX_W-1:0] p0,
                            input logic [hsr_pkg::PIX_W-1:0] p1,
                            input logic [hsr_pkg::PIX_W-1:0] p2,
                            input logic [hsr_pkg::TRANS_W-1:0] t);
    @(negedge clk);
    start   = 1'b1;
    pix_ch0 = p0;
    pix_ch1 = p1;
    pix_ch2 = p2;
    trans   = t;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(p0, p1, p2, t);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stops the sender and waits for every predicted pixel plus the pipeline depth.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hsr_pkg::LIGHT_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_light(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [hsr_pkg::PIX_W-1:0] rand_pix();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return hsr_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly back to back, some short gaps, a few long ones, and no-gap bursts.
  task automatic random_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(20, 40);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50)      idle_cycles(0);
      else if (r < 85) idle_cycles($urandom_range(1, 3));
      else if (r < 97) idle_cycles($urandom_range(4, 10));
      else             idle_cycles($urandom_range(20, 60));
    end
  endtask

  task automatic random_phase(input int n_items, input bit hold_midway);
    logic [hsr_pkg::TRANS_W-1:0] t;
    int                          j;
    for (j = 0; j < n_items; j++) begin
      // Small transmissions push the radiance toward the clamps.
      case ($urandom_range(0, 9))
        0:       t = '0;
        1, 2, 3: t = hsr_pkg::TRANS_W'($urandom_range(1, 255));
        4:       t = hsr_pkg::TRANS_W'(1 << hsr_pkg::TRANS_FRAC_BITS);
        default: t = hsr_pkg::TRANS_W'($urandom_range(0, (1 << hsr_pkg::TRANS_W) - 1));
      endcase
      send_pixel(rand_pix(), rand_pix(), rand_pix(), t);
      if (hold_midway && j == n_items / 2) drain_results();
      else random_gap();
    end
  endtask

  initial begin
    logic [hsr_pkg::LIGHT_W-1:0] phase_light [3];
    int                          ph;
    int                          c;
    sb         = new();
    burst_left = 0;
    rst        = 1'b1;
    start      = 1'b0;
    pix_ch0    = '0;
    pix_ch1    = '0;
    pix_ch2    = '0;
    trans      = '0;
    cfg_valid  = 1'b0;
    cfg_index  = hsr_pkg::REG_LIGHT_CH0;
    cfg_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pixels under the reset light of 255.0: zero and full transmission,
    // pixels at the light level, and dark pixels that go negative.
    send_pixel(8'd0,   8'd0,   8'd0,   13'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 13'd0);
    send_pixel(8'd0,   8'd128, 8'd255, 13'd1);
    send_pixel(8'd0,   8'd128, 8'd255, 13'd4096);
    idle_cycles(2);
    send_pixel(8'd255, 8'd0,   8'd128, 13'd8191);
    send_pixel(8'd1,   8'd2,   8'd3,   13'd4095);
    send_pixel(8'd128, 8'd128, 8'd128, 13'd2048);
    send_pixel(8'd254, 8'd1,   8'd127, 13'd4097);
    idle_cycles(5);
    send_pixel(8'd0,   8'd255, 8'd0,   13'd8190);
    send_pixel(8'd170, 8'd85,  8'd51,  13'd16);
    send_pixel(8'd85,  8'd170, 8'd204, 13'd64);
    drain_results();

    // Zero light, mid light and light above 255.0; a write to the spare index is dropped.
    write_reg(hsr_pkg::REG_LIGHT_CH0, 16'h0000);
    write_reg(hsr_pkg::REG_LIGHT_CH1, 16'h8000);
    write_reg(hsr_pkg::REG_LIGHT_CH2, 16'hFFFF);
    write_reg(REG_SPARE,              16'h1234);
    send_pixel(8'd255, 8'd255, 8'd255, 13'd1);
    send_pixel(8'd0,   8'd0,   8'd0,   13'd1);
    send_pixel(8'd200, 8'd100, 8'd50,  13'd0);
    send_pixel(8'd128, 8'd128, 8'd255, 13'd4096);
    idle_cycles(3);
    send_pixel(8'd1,   8'd127, 8'd254, 13'd8191);
    send_pixel(8'd255, 8'd0,   8'd255, 13'd2);
    send_pixel(8'd0,   8'd255, 8'd0,   13'd300);
    send_pixel(8'd64,  8'd192, 8'd32,  13'd5000);
    drain_results();

    // Random phases, each under its own light setting.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      for (c = 0; c < 3; c++) begin
        case (ph)
          0:       phase_light[c] = '0;
          1:       phase_light[c] = '1;
          2:       phase_light[c] = hsr_pkg::LIGHT_RESET;
          default: phase_light[c] =
                     hsr_pkg::LIGHT_W'($urandom_range(0, (1 << hsr_pkg::LIGHT_W) - 1));
        endcase
      end
      write_reg(hsr_pkg::REG_LIGHT_CH2, phase_light[2]);
      write_reg(hsr_pkg::REG_LIGHT_CH0, phase_light[0]);
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_SPARE,
                  hsr_pkg::LIGHT_W'($urandom_range(0, (1 << hsr_pkg::LIGHT_W) - 1)));
      write_reg(hsr_pkg::REG_LIGHT_CH1, phase_light[1]);
      random_phase(PHASE_ITEMS, ph == 3);
      drain_results();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** haze_scene_radiance_recover_top: PASSED **");
    end else begin
      $display("** haze_scene_radiance_recover_top: FAILED **");
    end
    $finish;
  end

endmodule

### haze_scene_radiance_recover_top.f
hdl/hsr_pkg.sv
hdl/hsr_front.sv
hdl/hsr_div_step.sv
hdl/haze_scene_radiance_recover_top.sv
dv/tb.sv
